// ----- hw/rtl/urhb_pkg.sv -----
// Shared constants, operation codes and inter-module structs for the
// undo/redo history buffer. No dependencies; imported by the core and control modules.
`default_nettype none

package urhb_pkg;

  // Storage geometry of the history ring.
  localparam int DEPTH      = 16;
  localparam int ENTRY_BITS = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Capacity register width and its reset value.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  // Operation codes carried by the func field.
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_UNDO  = 2'd1,
    FUNC_REDO  = 2'd2,
    FUNC_FIRST = 2'd3
  } func_t;

  // One access to the history memory.
  typedef struct packed {
    logic                  en;
    logic                  we;
    logic [ADDR_W-1:0]     addr;
    logic [ENTRY_BITS-1:0] wdata;
  } mem_req_t;

  // Status of one item, carried from the access cycle to the output stage.
  typedef struct packed {
    logic                    rd;
    logic                    ok;
    logic [CNT_W-1:0]        count;
    logic signed [CNT_W-1:0] cursor;
  } res_info_t;

endpackage

`default_nettype wire

// ----- hw/rtl/undo_redo_history_buffer_core.sv -----
// Top level of the undo/redo history buffer: control, history RAM and the
// two-stage result path. Uses urhb_pkg, urhb_ctrl and urhb_ram.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+----------------
//  in      | in_func, in_new_entry                    | in_valid/in_ready
//  out     | out_entry_out, out_ok, out_entry_count,  | out_valid/out_ready
//          | out_cursor_pos                           |
//  cfg     | cfg_wr_data (capacity)                   | cfg_wr_en
//
// An item does its RAM access, if it makes one, in the cycle it is accepted; its
// result then moves to the output register once that frees up, one item per cycle while the output is not stalled.
// The single RAM port sets that rate: each item makes at most one access.
// Reset clears pointers and valid flags; the RAM is not cleared.
// A stalled output holds its item; input stalls only when both stages are full.
`default_nettype none

module undo_redo_history_buffer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_new_entry,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_entry_out,
  output logic             out_ok,
  output logic [4:0]       out_entry_count,
  output logic signed [4:0] out_cursor_pos
);

  import urhb_pkg::*;

  mem_req_t              mem_req;
  res_info_t             res_info;
  res_info_t             s1_info_r;
  logic                  s1_v_r;
  logic                  out_v_r;
  logic                  acc;
  logic                  s1_adv;
  logic [ENTRY_BITS-1:0] rdata;
  logic [ENTRY_BITS-1:0] out_entry_r;
  logic                  out_ok_r;
  logic [CNT_W-1:0]      out_count_r;
  logic signed [CNT_W-1:0] out_cursor_r;

  // Handshake: the access stage moves on when the output register frees up.
  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign acc      = in_valid && in_ready;

  urhb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .func        (in_func),
    .new_entry   (in_new_entry),
    .mem_req     (mem_req),
    .res_info    (res_info)
  );

  // Read data holds while stage one stalls, since no new access is issued.
  urhb_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // Valid flags of the access stage and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload of both stages; failed or non-read items return a zero entry.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_info_r <= res_info;
    end
    if (s1_adv && s1_v_r) begin
      out_entry_r  <= s1_info_r.rd ? rdata : '0;
      out_ok_r     <= s1_info_r.ok;
      out_count_r  <= s1_info_r.count;
      out_cursor_r <= s1_info_r.cursor;
    end
  end

  assign out_valid       = out_v_r;
  assign out_entry_out   = out_entry_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = out_count_r;
  assign out_cursor_pos  = out_cursor_r;

endmodule

`default_nettype wire

// ----- hw/rtl/urhb_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// Self-contained; used by the history buffer to hold entry words.
`default_nettype none

module urhb_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH_P)-1:0] addr,
  input  wire logic [WIDTH_P-1:0]         wdata,
  output logic      [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // One access per cycle: a write, or a read whose data shows next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/urhb_ctrl.sv -----
// History pointers (oldest, count, cursor), capacity register and the
// per-item decision logic that issues at most one memory access. Uses urhb_pkg.
`default_nettype none

module urhb_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [urhb_pkg::CAP_W-1:0] cfg_wr_data,
  input  wire logic                      acc,
  input  wire logic [1:0]                func,
  input  wire logic [urhb_pkg::ENTRY_BITS-1:0] new_entry,
  output urhb_pkg::mem_req_t             mem_req,
  output urhb_pkg::res_info_t            res_info
);

  import urhb_pkg::*;

  logic [ADDR_W-1:0]        oldest_r, oldest_nxt;
  logic [CNT_W-1:0]         held_r, held_nxt;
  logic signed [CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [CAP_W-1:0]         cap_r;
  logic [CNT_W-1:0]         eff_cap;
  logic [CNT_W-1:0]         cur_inc, cur_dec;
  logic signed [CNT_W:0]    cur_s, held_s;
  logic                     at_tail;
  func_t                    op;

  // Ring address of the entry at logical offset off from the oldest entry.
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + {1'b0, off};
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Capacity of zero acts as one; anything above the ring size saturates.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(cap_r) > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  // Signed views for the cursor range checks.
  assign op      = func_t'(func);
  assign cur_s   = {cursor_r[CNT_W-1], cursor_r};
  assign held_s  = {1'b0, held_r};
  assign cur_inc = cursor_r + CNT_W'(1);
  assign cur_dec = cursor_r - CNT_W'(1);
  assign at_tail = (cur_s == held_s - (CNT_W+1)'(1));

  // Per-item decision: next pointers, the memory access and the status.
  always_comb begin
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    cursor_nxt    = cursor_r;
    mem_req.en    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = phys(oldest_r, cur_inc);
    mem_req.wdata = new_entry;
    res_info.rd   = 1'b0;
    res_info.ok   = 1'b0;
    if (acc) begin
      case (op)
        FUNC_ADD: begin
          // Every add writes just past the cursor.
          mem_req.en  = 1'b1;
          mem_req.we  = 1'b1;
          res_info.ok = 1'b1;
          if (!at_tail) begin
            held_nxt   = cur_inc + CNT_W'(1);
            cursor_nxt = cur_inc;
          end else if (held_r >= eff_cap) begin
            oldest_nxt = (oldest_r == ADDR_W'(DEPTH - 1)) ? '0 : oldest_r + ADDR_W'(1);
          end else begin
            held_nxt   = held_r + CNT_W'(1);
            cursor_nxt = cur_inc;
          end
        end
        FUNC_UNDO: begin
          if (cur_s > 0 && cur_s <= held_s) begin
            cursor_nxt   = cur_dec;
            mem_req.en   = 1'b1;
            mem_req.addr = phys(oldest_r, cur_dec);
            res_info.rd  = 1'b1;
            res_info.ok  = 1'b1;
          end
        end
        FUNC_REDO: begin
          if (cur_s < held_s - (CNT_W+1)'(1)) begin
            cursor_nxt  = cur_inc;
            mem_req.en  = 1'b1;
            res_info.rd = 1'b1;
            res_info.ok = 1'b1;
          end
        end
        default: begin
          if (held_r != '0) begin
            mem_req.en   = 1'b1;
            mem_req.addr = oldest_r;
            res_info.rd  = 1'b1;
            res_info.ok  = 1'b1;
          end
        end
      endcase
    end
    res_info.count  = held_nxt;
    res_info.cursor = cursor_nxt;
  end

  // Pointer and capacity registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      held_r   <= '0;
      cursor_r <= '1;
      cap_r    <= CAP_RESET;
    end else begin
      oldest_r <= oldest_nxt;
      held_r   <= held_nxt;
      cursor_r <= cursor_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // The cursor never points past the newest entry.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_s <= held_s - (CNT_W+1)'(1))
    else $error("cursor beyond newest entry");

  // An empty history always has the cursor at minus one.
  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0) |-> (cursor_r == '1))
    else $error("empty history with cursor set");

  // The count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("entry count above ring size");

  // A full tail add keeps count and cursor and advances the oldest pointer.
  a_full_tail_add: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == FUNC_ADD && at_tail && held_r >= eff_cap) |=>
      (held_r == $past(held_r) && cursor_r == $past(cursor_r) &&
       oldest_r != $past(oldest_r)))
    else $error("full tail add changed count or cursor");

endmodule

`default_nettype wire
